// File: rtl/dis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_pkg: shared types and codes for the interval set
// Request kinds, result status codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dis_pkg;

	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_CLEAR  = 3'd1;
	localparam logic [2:0] KIND_POINT  = 3'd2;
	localparam logic [2:0] KIND_ANY    = 3'd3;
	localparam logic [2:0] KIND_ALL    = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_BUILD,
		S_COPY,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic load;        // take the request
		logic scan_start;  // reset scan index and accumulators
		logic scan_step;   // one table entry per cycle
		logic build_start;
		logic build_step;  // one source entry per cycle into the scratch table
		logic copy_start;
		logic copy_step;   // scratch back into the table
		logic finish;      // capture the result beat
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic build_last;
		logic copy_last;
		logic empty_span;  // empty span for a span kind
		logic modifies;    // insert or clear request
		logic overflow;    // operation would overflow the table
	} dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/dis_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_ctrl: request sequencer
// Walks each request through a scan pass, then build and copy passes for an
// insert or clear that fits, and hands the result beat to the output register.
// ----------------------------------------------------------------------------
module dis_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              out_free,
	input  wire dis_pkg::dp_stat_t stat,
	output dis_pkg::dp_cmd_t       cmd,
	output logic                   busy
);

	dis_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dis_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dis_pkg::S_IDLE: begin
				if (in_fire) state_nxt = dis_pkg::S_SCAN;
			end
			dis_pkg::S_SCAN: begin
				if (stat.empty_span) state_nxt = dis_pkg::S_RESULT;
				else if (stat.scan_last) state_nxt = dis_pkg::S_DECIDE;
			end
			dis_pkg::S_DECIDE: begin
				if (stat.modifies && !stat.overflow) state_nxt = dis_pkg::S_BUILD;
				else state_nxt = dis_pkg::S_RESULT;
			end
			dis_pkg::S_BUILD: begin
				if (stat.build_last) state_nxt = dis_pkg::S_COPY;
			end
			dis_pkg::S_COPY: begin
				if (stat.copy_last) state_nxt = dis_pkg::S_RESULT;
			end
			dis_pkg::S_RESULT: begin
				if (out_free) state_nxt = dis_pkg::S_IDLE;
			end
			default: state_nxt = dis_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			dis_pkg::S_IDLE: begin
				busy           = 1'b0;
				cmd.load       = in_fire;
				cmd.scan_start = in_fire;
			end
			dis_pkg::S_SCAN: begin
				cmd.scan_step = !stat.empty_span;
			end
			dis_pkg::S_DECIDE: begin
				cmd.build_start = 1'b1;
			end
			dis_pkg::S_BUILD: begin
				cmd.build_step = 1'b1;
				cmd.copy_start = stat.build_last;
			end
			dis_pkg::S_COPY: begin
				cmd.copy_step = 1'b1;
			end
			dis_pkg::S_RESULT: begin
				cmd.finish = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/dis_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_dp: interval table datapath
// Holds the table, a scratch table, the scan accumulators and the merge and
// trim logic; one table entry is handled per cycle.
// ----------------------------------------------------------------------------
module dis_dp #(
	parameter int MAX_INTERVALS = 16,
	parameter int COORD_BITS    = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dis_pkg::dp_cmd_t      cmd,
	input  wire logic [2:0]            kind,
	input  wire logic [COORD_BITS-1:0] lo,
	input  wire logic [COORD_BITS-1:0] hi,
	output dis_pkg::dp_stat_t          stat,
	output logic                       res_answer,
	output logic [1:0]                 res_status,
	output logic [4:0]                 res_count
);

	localparam int IW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	// scratch may briefly need two more slots than the table
	localparam int NW = $clog2(MAX_INTERVALS + 3);

	logic [COORD_BITS-1:0] tab_s_q [MAX_INTERVALS];
	logic [COORD_BITS-1:0] tab_e_q [MAX_INTERVALS];
	logic [COORD_BITS-1:0] new_s_q [MAX_INTERVALS];
	logic [COORD_BITS-1:0] new_e_q [MAX_INTERVALS];

	logic [CW-1:0]         count_q;
	logic [2:0]            kind_q;
	logic [COORD_BITS-1:0] lo_q, hi_q;
	logic [CW-1:0]         idx_q;
	logic [NW-1:0]         n_q;
	logic                  placed_q;
	logic                  answer_q;
	logic                  overflow_q;
	logic                  merged_q;
	logic [NW:0]           pieces_q;
	logic [COORD_BITS-1:0] ms_q, me_q;

	logic [COORD_BITS-1:0] a, b;
	logic [IW-1:0]         rd_idx;
	logic                  in_range;
	logic                  span_kind, empty;
	logic                  touch;
	logic                  ovf_now;

	assign rd_idx   = idx_q[IW-1:0];
	assign in_range = idx_q < count_q;
	assign a        = tab_s_q[rd_idx];
	assign b        = tab_e_q[rd_idx];
	assign touch    = (a <= hi_q) && (b >= lo_q);

	assign span_kind = (kind_q == dis_pkg::KIND_INSERT) || (kind_q == dis_pkg::KIND_CLEAR)
		|| (kind_q == dis_pkg::KIND_ANY) || (kind_q == dis_pkg::KIND_ALL);
	assign empty     = span_kind && (hi_q <= lo_q);

	// taken from the scan accumulators once the scan pass is over
	assign ovf_now = (kind_q == dis_pkg::KIND_INSERT)
		? (!merged_q && (count_q >= CW'(MAX_INTERVALS)))
		: (pieces_q > (NW+1)'(MAX_INTERVALS));

	always_comb begin
		stat            = '0;
		stat.scan_last  = !in_range || (idx_q == CW'(MAX_INTERVALS - 1));
		// build runs one step past the last entry to place a pending merged span
		stat.build_last = !in_range;
		stat.copy_last  = (idx_q + CW'(1) >= CW'(n_q)) || (idx_q == CW'(MAX_INTERVALS - 1));
		stat.empty_span = empty;
		stat.modifies   = (kind_q == dis_pkg::KIND_INSERT) || (kind_q == dis_pkg::KIND_CLEAR);
		stat.overflow   = ovf_now;
	end

	logic [NW:0] pieces_add;
	always_comb begin
		pieces_add = '0;
		if (a < lo_q) pieces_add = pieces_add + (NW+1)'(1);
		if (b > hi_q) pieces_add = pieces_add + (NW+1)'(1);
	end

	// scratch writes during build: up to two entries in one cycle
	logic                  w0, w1;
	logic [COORD_BITS-1:0] w0_s, w0_e, w1_s, w1_e;
	logic [NW-1:0]         n_nxt;
	logic                  placed_nxt;

	always_comb begin
		w0 = 1'b0; w1 = 1'b0;
		w0_s = a; w0_e = b; w1_s = a; w1_e = b;
		placed_nxt = placed_q;
		if (!in_range) begin
			// tail: place the merged span if still pending
			if (kind_q == dis_pkg::KIND_INSERT && !placed_q) begin
				w0 = 1'b1; w0_s = ms_q; w0_e = me_q; placed_nxt = 1'b1;
			end
		end else if (kind_q == dis_pkg::KIND_INSERT) begin
			if (!touch) begin
				if (!placed_q && a > ms_q) begin
					w0 = 1'b1; w0_s = ms_q; w0_e = me_q;
					w1 = 1'b1; w1_s = a; w1_e = b;
					placed_nxt = 1'b1;
				end else begin
					w0 = 1'b1;
				end
			end
		end else begin
			if (a < lo_q) begin
				w0 = 1'b1; w0_s = a; w0_e = (b < lo_q) ? b : lo_q;
			end
			if (b > hi_q) begin
				w1 = 1'b1; w1_s = (a > hi_q) ? a : hi_q; w1_e = b;
			end
			if (!w0 && w1) begin
				w0 = 1'b1; w0_s = w1_s; w0_e = w1_e; w1 = 1'b0;
			end
		end
		n_nxt = n_q + NW'(w0) + NW'(w1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			lo_q   <= lo;
			hi_q   <= hi;
		end
		if (cmd.scan_start) begin
			ms_q <= lo;
			me_q <= hi;
		end else if (cmd.scan_step && in_range && touch) begin
			if (a < ms_q) ms_q <= a;
			if (b > me_q) me_q <= b;
		end
		if (cmd.build_step) begin
			if (w0 && n_q < NW'(MAX_INTERVALS)) begin
				new_s_q[n_q[IW-1:0]] <= w0_s;
				new_e_q[n_q[IW-1:0]] <= w0_e;
			end
			if (w1 && (n_q + NW'(1)) < NW'(MAX_INTERVALS)) begin
				new_s_q[IW'(n_q + NW'(1))] <= w1_s;
				new_e_q[IW'(n_q + NW'(1))] <= w1_e;
			end
		end
		if (cmd.copy_step && CW'(idx_q) < CW'(n_q)) begin
			tab_s_q[rd_idx] <= new_s_q[rd_idx];
			tab_e_q[rd_idx] <= new_e_q[rd_idx];
		end
		if (cmd.finish) begin
			res_answer <= answer_q && !empty;
			res_status <= empty ? dis_pkg::ST_EMPTY
				: (stat.modifies && overflow_q) ? dis_pkg::ST_FULL : dis_pkg::ST_DONE;
			res_count  <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			n_q        <= '0;
			placed_q   <= 1'b0;
			answer_q   <= 1'b0;
			overflow_q <= 1'b0;
			merged_q   <= 1'b0;
			pieces_q   <= '0;
		end else begin
			if (cmd.scan_start || cmd.build_start || cmd.copy_start) begin
				idx_q <= '0;
			end else if (cmd.scan_step || cmd.build_step || cmd.copy_step) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.scan_start) begin
				answer_q <= 1'b0;
				merged_q <= 1'b0;
				pieces_q <= '0;
			end else if (cmd.scan_step) begin
				if (in_range) begin
					pieces_q <= pieces_q + pieces_add;
					if (touch) merged_q <= 1'b1;
					case (kind_q)
						dis_pkg::KIND_POINT:
							if (a <= lo_q && lo_q < b) answer_q <= 1'b1;
						dis_pkg::KIND_ANY:
							if (a < hi_q && b > lo_q) answer_q <= 1'b1;
						dis_pkg::KIND_ALL:
							if (a <= lo_q && b >= hi_q) answer_q <= 1'b1;
						default: ;
					endcase
				end
			end
			if (cmd.build_start) begin
				n_q        <= '0;
				placed_q   <= 1'b0;
				overflow_q <= ovf_now;
			end else if (cmd.build_step) begin
				n_q      <= n_nxt;
				placed_q <= placed_nxt;
			end
			if (cmd.copy_start) begin
				// final build step may add entries this same cycle
				count_q <= CW'(n_nxt);
			end
			if (cmd.load) overflow_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: rtl/disjoint_interval_set.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disjoint_interval_set: sorted table of disjoint half-open intervals
// Insert, clear and three coverage queries; one result beat per request.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------
//  request  | in_valid / in_ready | kind, lo, hi
//  result   | out_valid/out_ready | answer, status, stored_count
//
//  A query scans the held entries one per cycle and registers its result beat
//  after the scan pass. Insert or clear adds a build pass over the held entries
//  plus one tail step, and a copy pass over the new entries, before the result
//  beat. An empty span goes from the scan state straight to the result. The
//  next request can be taken in the cycle after the result beat is registered.
//  Reset empties the table at once; no clearing pass.
//  A stalled result beat holds in the output register; a finished request
//  waits for that register before it is handed over.
// ----------------------------------------------------------------------------
module disjoint_interval_set #(
	parameter int MAX_INTERVALS = 16,
	parameter int COORD_BITS    = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [2:0]            kind,
	input  wire logic [COORD_BITS-1:0] lo,
	input  wire logic [COORD_BITS-1:0] hi,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       answer,
	output logic [1:0]                 status,
	output logic [4:0]                 stored_count
);

	dis_pkg::dp_cmd_t  cmd;
	dis_pkg::dp_stat_t stat;
	logic              busy;
	logic              out_valid_q;
	logic              in_fire;
	logic              out_free;

	assign in_ready  = !busy;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	dis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	dis_dp #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.COORD_BITS    (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.lo         (lo),
		.hi         (hi),
		.stat       (stat),
		.res_answer (answer),
		.res_status (status),
		.res_count  (stored_count)
	);

endmodule
`default_nettype wire

// File: rtl/dis_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_checker: port-level checks for the interval set
// Watches both channels of the top level.
// ----------------------------------------------------------------------------
module dis_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       answer,
	input wire logic [1:0] status,
	input wire logic [4:0] stored_count
);

	// result held while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(answer) && $stable(status)
			&& $stable(stored_count))
		else $error("result beat changed while stalled");

	// a waiting request is not withdrawn
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request withdrawn before accept");

	// a taken request is not accepted again next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back-to-back accept");

	// status is a defined code and answer is set only with status done
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3 && !(answer && status != dis_pkg::ST_DONE))
		else $error("bad result code");

endmodule

bind disjoint_interval_set dis_checker u_dis_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.answer       (answer),
	.status       (status),
	.stored_count (stored_count)
);
`default_nettype wire
